// ----- hdl/asgr_pkg.sv -----
// Shared types, codes and palette tables for the ANSI SGR color decoder.
// No dependencies; imported by every other file of the block except asgr_if.sv.
`timescale 1ns / 1ps

package asgr_pkg;

  typedef logic [23:0] color_t;

  // Result kinds
  localparam logic [1:0] KIND_GLYPH = 2'd0;
  localparam logic [1:0] KIND_LF    = 2'd1;
  localparam logic [1:0] KIND_CR    = 2'd2;

  // Parser phases
  localparam logic [1:0] PH_TEXT = 2'd0;
  localparam logic [1:0] PH_ESC  = 2'd1;
  localparam logic [1:0] PH_LIST = 2'd2;
  localparam logic [1:0] PH_SKIP = 2'd3;

  // Byte codes
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_M     = 8'h6d;
  localparam logic [7:0] CH_HIGH  = 8'h80;

  localparam color_t FG_DEFAULT = 24'ha6a6a6;
  localparam color_t BG_DEFAULT = 24'h121212;

  // Extended color selectors following 38/48
  localparam logic [15:0] EXT_INDEXED = 16'd5;
  localparam logic [15:0] EXT_RGB     = 16'd2;

  // Decoded SGR operations
  typedef logic [3:0] sgr_op_t;
  localparam sgr_op_t OP_NONE     = 4'd0;
  localparam sgr_op_t OP_RESET    = 4'd1;
  localparam sgr_op_t OP_SWAP     = 4'd2;
  localparam sgr_op_t OP_FG_DARK  = 4'd3;
  localparam sgr_op_t OP_BG_DARK  = 4'd4;
  localparam sgr_op_t OP_FG_DEF   = 4'd5;
  localparam sgr_op_t OP_BG_DEF   = 4'd6;
  localparam sgr_op_t OP_FG_LIGHT = 4'd7;
  localparam sgr_op_t OP_BG_LIGHT = 4'd8;
  localparam sgr_op_t OP_EXT      = 4'd9;

  typedef struct packed {
    sgr_op_t    op;
    logic [2:0] sel;   // palette entry; for OP_EXT bit 0 set means background
  } sgr_dec_t;

  // Result of one accepted byte, before colors are attached
  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [6:0] code;
  } res_t;

  // One queued output request
  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] code;
    color_t     fg;
    color_t     bg;
  } out_t;

  function automatic color_t dark_pal(input logic [2:0] i);
    color_t c;
    unique case (i)
      3'd0: c = 24'h121212;
      3'd1: c = 24'ha61010;
      3'd2: c = 24'h10a610;
      3'd3: c = 24'ha66010;
      3'd4: c = 24'h1010a6;
      3'd5: c = 24'ha610a6;
      3'd6: c = 24'h10a6a6;
      default: c = 24'ha6a6a6;
    endcase
    return c;
  endfunction

  function automatic color_t light_pal(input logic [2:0] i);
    color_t c;
    unique case (i)
      3'd0: c = 24'h323232;
      3'd1: c = 24'hd01010;
      3'd2: c = 24'h10d010;
      3'd3: c = 24'hd0d010;
      3'd4: c = 24'h1060d0;
      3'd5: c = 24'hd010d0;
      3'd6: c = 24'h10d0d0;
      default: c = 24'hd0d0d0;
    endcase
    return c;
  endfunction

  // Range compare unit shared by every parameter the walker visits
  function automatic sgr_dec_t sgr_decode(input logic [15:0] v);
    sgr_dec_t d;
    d.op  = OP_NONE;
    d.sel = 3'd0;
    priority if (v == 16'd0) begin
      d.op = OP_RESET;
    end else if (v == 16'd7) begin
      d.op = OP_SWAP;
    end else if (v >= 16'd30 && v <= 16'd37) begin
      d.op  = OP_FG_DARK;
      d.sel = 3'(v - 16'd30);
    end else if (v == 16'd38) begin
      d.op = OP_EXT;
    end else if (v == 16'd48) begin
      d.op  = OP_EXT;
      d.sel = 3'd1;
    end else if (v == 16'd39) begin
      d.op = OP_FG_DEF;
    end else if (v >= 16'd40 && v <= 16'd47) begin
      d.op  = OP_BG_DARK;
      d.sel = 3'(v - 16'd40);
    end else if (v == 16'd49) begin
      d.op = OP_BG_DEF;
    end else if (v >= 16'd90 && v <= 16'd97) begin
      d.op  = OP_FG_LIGHT;
      d.sel = 3'(v - 16'd90);
    end else if (v >= 16'd100 && v <= 16'd107) begin
      d.op  = OP_BG_LIGHT;
      d.sel = 3'(v - 16'd100);
    end else begin
      d.op = OP_NONE;
    end
    return d;
  endfunction

endpackage

// ----- hdl/asgr_if.sv -----
// Valid/ready channel interfaces for the decoder's byte input and result output.
// Standalone; no package dependency.
`timescale 1ns / 1ps

interface asgr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_in_write;

  modport source (output valid, output byte_in, output last_in_write, input ready);
  modport sink   (input valid, input byte_in, input last_in_write, output ready);
endinterface

interface asgr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [6:0]  char_code;
  logic [23:0] fg_color;
  logic [23:0] bg_color;

  modport source (output valid, output kind, output char_code, output fg_color,
                  output bg_color, input ready);
  modport sink   (input valid, input kind, input char_code, input fg_color,
                  input bg_color, output ready);
endinterface

// ----- hdl/asgr_parse.sv -----
// Byte parser: escape phase tracking, decimal parameter store and text results.
// Depends on asgr_pkg.
`timescale 1ns / 1ps

module asgr_parse
  import asgr_pkg::*;
#(
  parameter int MAX_PARAMS = 10
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                acc,
  input  logic [7:0]                          byte_in,
  input  logic                                last_in_write,
  input  logic                                walk_busy,
  input  logic [$clog2(MAX_PARAMS)-1:0]       walk_addr,
  output logic [15:0]                         rd_data,
  output logic                                walk_start,
  output logic [$clog2(MAX_PARAMS+1)-1:0]     walk_cnt,
  output res_t                                res
);

  localparam int IW = $clog2(MAX_PARAMS);
  localparam int CW = $clog2(MAX_PARAMS + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_PARAMS);

  logic [15:0]           store_r [MAX_PARAMS];
  logic [MAX_PARAMS-1:0] vld_r, vld_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [1:0]            phase_r, phase_nxt;
  logic [IW-1:0]         rd_a;
  logic                  wr_en;
  logic [19:0]           prod;
  logic [15:0]           sat;
  logic                  digit;
  res_t                  txt_res;
  logic                  txt_esc;

  // single read port, shared between digit accumulation and the SGR walk
  assign rd_a    = walk_busy ? walk_addr : idx_r;
  assign rd_data = (int'(rd_a) < MAX_PARAMS && vld_r[rd_a]) ? store_r[rd_a] : 16'd0;

  assign digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
  // v*10 + d as two shifts and two adds
  assign prod  = ({4'd0, rd_data} << 3) + ({4'd0, rd_data} << 1) + {16'd0, byte_in[3:0]};
  assign sat   = (prod > 20'h0ffff) ? 16'hffff : prod[15:0];

  assign walk_cnt = CW'(idx_r) + CW'(1);

  always_comb begin
    txt_res = '0;
    txt_esc = 1'b0;
    if (byte_in >= CH_SPACE && byte_in < CH_HIGH) begin
      txt_res.valid = 1'b1;
      txt_res.kind  = KIND_GLYPH;
      txt_res.code  = byte_in[6:0];
    end else if (byte_in == CH_LF) begin
      txt_res.valid = 1'b1;
      txt_res.kind  = KIND_LF;
    end else if (byte_in == CH_CR) begin
      txt_res.valid = 1'b1;
      txt_res.kind  = KIND_CR;
    end else if (byte_in == CH_ESC) begin
      txt_esc = 1'b1;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    vld_nxt    = vld_r;
    wr_en      = 1'b0;
    walk_start = 1'b0;
    res        = '0;
    if (acc) begin
      unique case (phase_r)
        PH_TEXT: begin
          res = txt_res;
          if (txt_esc) phase_nxt = PH_ESC;
        end
        PH_ESC: begin
          if (byte_in == CH_LBRK) begin
            // list is cleared only on entry; nothing reads it before then
            vld_nxt   = '0;
            idx_nxt   = '0;
            phase_nxt = PH_LIST;
          end else begin
            res       = txt_res;
            phase_nxt = txt_esc ? PH_ESC : PH_TEXT;
          end
        end
        PH_LIST: begin
          if (digit) begin
            wr_en          = 1'b1;
            vld_nxt[idx_r] = 1'b1;
          end else if (byte_in == CH_SEMI) begin
            if (CW'(idx_r) + CW'(1) >= MAX_C) phase_nxt = PH_SKIP;
            else                              idx_nxt   = idx_r + IW'(1);
          end else begin
            walk_start = (byte_in == CH_M);
            phase_nxt  = PH_TEXT;
          end
        end
        default: begin
          if (!digit && byte_in != CH_SEMI) phase_nxt = PH_TEXT;
        end
      endcase
      if (last_in_write) phase_nxt = PH_TEXT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TEXT;
      idx_r   <= '0;
      vld_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) store_r[idx_r] <= sat;
  end

endmodule

// ----- hdl/asgr_sgr_walk.sv -----
// SGR sequencer: walks the stored parameters one per cycle, apart from a skipped 38/48,
// through the shared decode/compare unit and updates the current colors. Depends on asgr_pkg.
`timescale 1ns / 1ps

module asgr_sgr_walk
  import asgr_pkg::*;
#(
  parameter int MAX_PARAMS = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [$clog2(MAX_PARAMS+1)-1:0] cnt,
  input  logic [15:0]                     rd_data,
  output logic [$clog2(MAX_PARAMS)-1:0]   rd_addr,
  output logic                            busy,
  output color_t                          cur_fg,
  output color_t                          cur_bg
);

  localparam int IW = $clog2(MAX_PARAMS);
  localparam int CW = $clog2(MAX_PARAMS + 1);

  localparam logic [2:0] W_IDLE = 3'd0;
  localparam logic [2:0] W_CODE = 3'd1;
  localparam logic [2:0] W_EXT  = 3'd2;
  localparam logic [2:0] W_IDX  = 3'd3;
  localparam logic [2:0] W_R    = 3'd4;
  localparam logic [2:0] W_G    = 3'd5;
  localparam logic [2:0] W_B    = 3'd6;

  logic [2:0]    st_r, st_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          to_bg_r, to_bg_nxt;
  logic [15:0]   rg_r, rg_nxt;
  color_t        fg_r, fg_nxt;
  color_t        bg_r, bg_nxt;
  color_t        ext_col;
  logic          ext_apply;
  sgr_dec_t      dec;
  logic [CW:0]   ptr_p1, ptr_p3;

  assign dec     = sgr_decode(rd_data);
  assign rd_addr = ptr_r[IW-1:0];
  assign busy    = (st_r != W_IDLE);
  assign cur_fg  = fg_r;
  assign cur_bg  = bg_r;
  assign ptr_p1  = {1'b0, ptr_r} + (CW+1)'(1);
  assign ptr_p3  = {1'b0, ptr_r} + (CW+1)'(3);

  always_comb begin
    st_nxt    = st_r;
    ptr_nxt   = ptr_r;
    cnt_nxt   = cnt_r;
    to_bg_nxt = to_bg_r;
    rg_nxt    = rg_r;
    fg_nxt    = fg_r;
    bg_nxt    = bg_r;
    ext_col   = {rg_r, rd_data[7:0]};
    ext_apply = 1'b0;
    unique case (st_r)
      W_IDLE: begin
        if (start) begin
          st_nxt  = W_CODE;
          ptr_nxt = '0;
          cnt_nxt = cnt;
        end
      end
      W_CODE: begin
        if (ptr_r >= cnt_r) begin
          st_nxt = W_IDLE;
        end else begin
          ptr_nxt = ptr_r + CW'(1);
          unique case (dec.op)
            OP_RESET: begin
              fg_nxt = FG_DEFAULT;
              bg_nxt = BG_DEFAULT;
            end
            OP_SWAP: begin
              fg_nxt = bg_r;
              bg_nxt = fg_r;
            end
            OP_FG_DARK:  fg_nxt = dark_pal(dec.sel);
            OP_BG_DARK:  bg_nxt = dark_pal(dec.sel);
            OP_FG_DEF:   fg_nxt = FG_DEFAULT;
            OP_BG_DEF:   bg_nxt = BG_DEFAULT;
            OP_FG_LIGHT: fg_nxt = light_pal(dec.sel);
            OP_BG_LIGHT: bg_nxt = light_pal(dec.sel);
            OP_EXT: begin
              to_bg_nxt = dec.sel[0];
              st_nxt    = W_EXT;
            end
            default: ;
          endcase
        end
      end
      W_EXT: begin
        // ptr points one past the 38/48; too few values means it is skipped
        priority if (ptr_p1 < {1'b0, cnt_r} && rd_data == EXT_INDEXED) begin
          st_nxt  = W_IDX;
          ptr_nxt = ptr_r + CW'(1);
        end else if (ptr_p3 < {1'b0, cnt_r} && rd_data == EXT_RGB) begin
          st_nxt  = W_R;
          ptr_nxt = ptr_r + CW'(1);
        end else begin
          st_nxt = W_CODE;
        end
      end
      W_IDX: begin
        ext_col   = dark_pal(rd_data[2:0]);
        ext_apply = 1'b1;
        ptr_nxt   = ptr_r + CW'(1);
        st_nxt    = W_CODE;
      end
      W_R: begin
        rg_nxt[15:8] = rd_data[7:0];
        ptr_nxt      = ptr_r + CW'(1);
        st_nxt       = W_G;
      end
      W_G: begin
        rg_nxt[7:0] = rd_data[7:0];
        ptr_nxt     = ptr_r + CW'(1);
        st_nxt      = W_B;
      end
      W_B: begin
        ext_apply = 1'b1;
        ptr_nxt   = ptr_r + CW'(1);
        st_nxt    = W_CODE;
      end
      default: st_nxt = W_IDLE;
    endcase
    if (ext_apply) begin
      if (to_bg_r) bg_nxt = ext_col;
      else         fg_nxt = ext_col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= W_IDLE;
      fg_r <= FG_DEFAULT;
      bg_r <= BG_DEFAULT;
    end else begin
      st_r <= st_nxt;
      fg_r <= fg_nxt;
      bg_r <= bg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    cnt_r   <= cnt_nxt;
    to_bg_r <= to_bg_nxt;
    rg_r    <= rg_nxt;
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> st_r == W_IDLE)
    else $error("walk started while busy");

  // W_EXT may look one past the list when 38/48 is the last value
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != W_IDLE && st_r != W_CODE && st_r != W_EXT) |-> ptr_r < cnt_r)
    else $error("walk read past the parameter count");

  a_rgb_seq: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == W_R |=> st_r == W_G ##1 st_r == W_B)
    else $error("rgb triple not read in order");

endmodule

// ----- hdl/ansi_sgr_color_stream_decoder.sv -----
// Top level: ANSI SGR color stream decoder.
// A result is registered in the output register, or in the skid entry while the output is stalled.
// Throughput: one byte per cycle outside stalls; a final 'm' holds the input while the
// sequencer walks the stored values.
// Output register plus one skid entry; the input also stalls while both are full.
// Reset: synchronous active-low; default colors, text phase, no clearing pass.
`timescale 1ns / 1ps

module ansi_sgr_color_stream_decoder
  import asgr_pkg::*;
#(
  parameter int MAX_PARAMS = 10
) (
  input  logic             clk,
  input  logic             rst_n,
  asgr_in_if.sink          in_chan,
  asgr_out_if.source       out_chan
);

  localparam int IW = $clog2(MAX_PARAMS);
  localparam int CW = $clog2(MAX_PARAMS + 1);

  logic          acc;
  logic          walk_busy;
  logic          walk_start;
  logic [IW-1:0] walk_addr;
  logic [CW-1:0] walk_cnt;
  logic [15:0]   rd_data;
  res_t          res;
  color_t        cur_fg;
  color_t        cur_bg;
  out_t          push_d;
  logic          pop;

  out_t o_r, o_nxt;
  out_t s_r, s_nxt;
  logic o_v_r, o_v_nxt;
  logic s_v_r, s_v_nxt;

  assign in_chan.ready = !walk_busy && !s_v_r;
  assign acc           = in_chan.valid && in_chan.ready;

  asgr_parse #(.MAX_PARAMS(MAX_PARAMS)) u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .byte_in       (in_chan.byte_in),
    .last_in_write (in_chan.last_in_write),
    .walk_busy     (walk_busy),
    .walk_addr     (walk_addr),
    .rd_data       (rd_data),
    .walk_start    (walk_start),
    .walk_cnt      (walk_cnt),
    .res           (res)
  );

  asgr_sgr_walk #(.MAX_PARAMS(MAX_PARAMS)) u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (walk_start),
    .cnt     (walk_cnt),
    .rd_data (rd_data),
    .rd_addr (walk_addr),
    .busy    (walk_busy),
    .cur_fg  (cur_fg),
    .cur_bg  (cur_bg)
  );

  assign push_d = '{kind: res.kind, code: res.code, fg: cur_fg, bg: cur_bg};
  assign pop    = o_v_r && out_chan.ready;

  // two-entry output queue: output register in front, skid entry behind
  always_comb begin
    o_nxt   = o_r;
    s_nxt   = s_r;
    o_v_nxt = o_v_r;
    s_v_nxt = s_v_r;
    if (!o_v_r || pop) begin
      if (s_v_r) begin
        o_nxt   = s_r;
        o_v_nxt = 1'b1;
        s_v_nxt = 1'b0;
      end else begin
        o_nxt   = push_d;
        o_v_nxt = res.valid;
      end
    end else if (res.valid) begin
      s_nxt   = push_d;
      s_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
      s_v_r <= 1'b0;
    end else begin
      o_v_r <= o_v_nxt;
      s_v_r <= s_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    o_r <= o_nxt;
    s_r <= s_nxt;
  end

  assign out_chan.valid     = o_v_r;
  assign out_chan.kind      = o_r.kind;
  assign out_chan.char_code = o_r.code;
  assign out_chan.fg_color  = o_r.fg;
  assign out_chan.bg_color  = o_r.bg;

  a_skid_behind: assert property (@(posedge clk) disable iff (!rst_n)
    s_v_r |-> o_v_r)
    else $error("skid entry held with empty output register");

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    walk_busy |-> !in_chan.ready)
    else $error("input taken during SGR walk");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && o_v_r && !out_chan.ready) |=> s_v_r)
    else $error("result lost while output stalled");

endmodule

// ----- tb/ansi_sgr_color_stream_decoder_tb.sv -----
// Testbench for ansi_sgr_color_stream_decoder: directed byte table, then random text and
// SGR escape traffic; results checked against typed rows or a color-tracking model.
// Depends on hdl/asgr_pkg.sv, hdl/asgr_if.sv and the decoder RTL.
`timescale 1ns / 1ps

module ansi_sgr_color_stream_decoder_tb;
  import asgr_pkg::*;

  localparam int MAX_PARAMS       = 10;
  localparam int CLK_PERIOD       = 12;
  localparam int RANDOM_BYTES     = 1150;
  localparam int SINK_HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES      = 2 * MAX_PARAMS + 8;
  localparam int CYCLE_LIMIT      = 1000000;

  // SGR code values
  localparam int SGR_RESET    = 0;
  localparam int SGR_SWAP     = 7;
  localparam int SGR_FG_BASE  = 30;
  localparam int SGR_FG_EXT   = 38;
  localparam int SGR_FG_DEF   = 39;
  localparam int SGR_BG_BASE  = 40;
  localparam int SGR_BG_EXT   = 48;
  localparam int SGR_BG_DEF   = 49;
  localparam int SGR_FG_LIGHT = 90;
  localparam int SGR_BG_LIGHT = 100;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       typed;   // expectation given in the row rather than by the model
    logic       has;
    out_t       res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  asgr_in_if  in_chan ();
  asgr_out_if out_chan ();

  ansi_sgr_color_stream_decoder #(.MAX_PARAMS(MAX_PARAMS)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Decoder model state
  color_t      pen_fg;
  color_t      pen_bg;
  logic [1:0]  scan_phase;
  logic [15:0] sgr_vals [MAX_PARAMS];
  int          sgr_slot;

  out_t        colored_chars [$];
  int          mismatches = 0;
  int          bytes_sent = 0;
  int unsigned cycle_cnt = 0;
  bit          steady = 1'b0;
  bit          sink_hold_ask = 1'b0;
  dir_row_t    dir_tab [$];

  function automatic color_t shade(input bit bright, input logic [2:0] idx);
    color_t c;
    case ({bright, idx})
      4'h0: c = 24'h121212;
      4'h1: c = 24'ha61010;
      4'h2: c = 24'h10a610;
      4'h3: c = 24'ha66010;
      4'h4: c = 24'h1010a6;
      4'h5: c = 24'ha610a6;
      4'h6: c = 24'h10a6a6;
      4'h7: c = 24'ha6a6a6;
      4'h8: c = 24'h323232;
      4'h9: c = 24'hd01010;
      4'ha: c = 24'h10d010;
      4'hb: c = 24'hd0d010;
      4'hc: c = 24'h1060d0;
      4'hd: c = 24'hd010d0;
      4'he: c = 24'h10d0d0;
      default: c = 24'hd0d0d0;
    endcase
    return c;
  endfunction

  function automatic void clear_args();
    foreach (sgr_vals[i]) sgr_vals[i] = '0;
    sgr_slot = 0;
  endfunction

  function automatic void apply_codes();
    int     n;
    int     k;
    int     v;
    color_t c;
    bit     hit;
    n = (sgr_slot + 1 > MAX_PARAMS) ? MAX_PARAMS : sgr_slot + 1;
    k = 0;
    while (k < n) begin
      v = sgr_vals[k];
      if (v == SGR_RESET) begin
        pen_fg = FG_DEFAULT;
        pen_bg = BG_DEFAULT;
      end else if (v == SGR_SWAP) begin
        c = pen_bg;
        pen_bg = pen_fg;
        pen_fg = c;
      end else if (v >= SGR_FG_BASE && v <= SGR_FG_BASE + 7) begin
        pen_fg = shade(1'b0, 3'(v - SGR_FG_BASE));
      end else if (v == SGR_FG_EXT || v == SGR_BG_EXT) begin
        // too few trailing values: the 38/48 is skipped and the rest read as codes
        hit = 1'b0;
        if (k + 2 < n && sgr_vals[k + 1] == EXT_INDEXED) begin
          c = shade(1'b0, sgr_vals[k + 2][2:0]);
          hit = 1'b1;
          k += 2;
        end else if (k + 4 < n && sgr_vals[k + 1] == EXT_RGB) begin
          c = {sgr_vals[k + 2][7:0], sgr_vals[k + 3][7:0], sgr_vals[k + 4][7:0]};
          hit = 1'b1;
          k += 4;
        end
        if (hit && v == SGR_FG_EXT) pen_fg = c;
        if (hit && v == SGR_BG_EXT) pen_bg = c;
      end else if (v == SGR_FG_DEF) begin
        pen_fg = FG_DEFAULT;
      end else if (v >= SGR_BG_BASE && v <= SGR_BG_BASE + 7) begin
        pen_bg = shade(1'b0, 3'(v - SGR_BG_BASE));
      end else if (v == SGR_BG_DEF) begin
        pen_bg = BG_DEFAULT;
      end else if (v >= SGR_FG_LIGHT && v <= SGR_FG_LIGHT + 7) begin
        pen_fg = shade(1'b1, 3'(v - SGR_FG_LIGHT));
      end else if (v >= SGR_BG_LIGHT && v <= SGR_BG_LIGHT + 7) begin
        pen_bg = shade(1'b1, 3'(v - SGR_BG_LIGHT));
      end
      k++;
    end
  endfunction

  function automatic void print_byte(input logic [7:0] b, output bit has, output out_t r);
    has = 1'b0;
    r = '0;
    r.fg = pen_fg;
    r.bg = pen_bg;
    if (b >= CH_SPACE && b < CH_HIGH) begin
      has = 1'b1;
      r.kind = KIND_GLYPH;
      r.code = b[6:0];
    end else if (b == CH_LF) begin
      has = 1'b1;
      r.kind = KIND_LF;
    end else if (b == CH_CR) begin
      has = 1'b1;
      r.kind = KIND_CR;
    end else if (b == CH_ESC) begin
      scan_phase = PH_ESC;
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic last,
                                      output bit has, output out_t r);
    bit          digit;
    int          slot;
    int unsigned acc;
    has = 1'b0;
    r = '0;
    digit = (b >= CH_ZERO && b <= CH_NINE);
    case (scan_phase)
      PH_TEXT: begin
        print_byte(b, has, r);
      end
      PH_ESC: begin
        if (b == CH_LBRK) begin
          clear_args();
          scan_phase = PH_LIST;
        end else begin
          scan_phase = PH_TEXT;
          print_byte(b, has, r);
        end
      end
      PH_LIST: begin
        slot = (sgr_slot >= MAX_PARAMS) ? MAX_PARAMS - 1 : sgr_slot;
        if (digit) begin
          acc = 32'(sgr_vals[slot]) * 10 + 32'(b - CH_ZERO);
          sgr_vals[slot] = (acc > 65535) ? 16'hffff : acc[15:0];
        end else if (b == CH_SEMI) begin
          if (slot + 1 >= MAX_PARAMS) scan_phase = PH_SKIP;
          else sgr_slot = slot + 1;
        end else begin
          if (b == CH_M) apply_codes();
          scan_phase = PH_TEXT;
          clear_args();
        end
      end
      default: begin
        if (!digit && b != CH_SEMI) begin
          scan_phase = PH_TEXT;
          clear_args();
        end
      end
    endcase
    if (last && scan_phase != PH_TEXT) begin
      scan_phase = PH_TEXT;
      clear_args();
    end
  endfunction

  // Directed table rows
  function automatic dir_row_t shown(input logic [7:0] b, input logic last,
                                     input logic [1:0] kind, input logic [6:0] code,
                                     input color_t fg, input color_t bg);
    dir_row_t row;
    row = '{b: b, last: last, typed: 1'b1, has: 1'b1, res: '{kind, code, fg, bg}};
    return row;
  endfunction

  function automatic dir_row_t silent(input logic [7:0] b, input logic last);
    dir_row_t row;
    row = '{b: b, last: last, typed: 1'b1, has: 1'b0, res: '0};
    return row;
  endfunction

  function automatic dir_row_t calc(input logic [7:0] b, input logic last);
    dir_row_t row;
    row = '{b: b, last: last, typed: 1'b0, has: 1'b0, res: '0};
    return row;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit stray_last();
    return ($urandom_range(0, 39) == 0);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                           input bit typed_has, input out_t typed_res);
    int   gap;
    bit   has;
    out_t r;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.byte_in       <= b;
    in_chan.last_in_write <= last;
    do @(posedge clk); while (!in_chan.ready);
    decode_byte(b, last, has, r);
    if (typed) begin
      has = typed_has;
      r = typed_res;
    end
    if (has) colored_chars.push_back(r);
  endtask

  task automatic put(input logic [7:0] b, input logic last);
    send_byte(b, last, 1'b0, 1'b0, '0);
    bytes_sent++;
  endtask

  task automatic send_number(input int v);
    string s;
    int    zeros;
    // an empty field reads as zero
    if (v == 0 && $urandom_range(0, 2) == 0) return;
    zeros = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
    repeat (zeros) put(CH_ZERO, stray_last());
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) put(s[i], stray_last());
  endtask

  function automatic int pick_code();
    case ($urandom_range(0, 13))
      0:       return SGR_RESET;
      1:       return SGR_SWAP;
      2, 3:    return SGR_FG_BASE + $urandom_range(0, 7);
      4:       return SGR_FG_DEF;
      5, 6:    return SGR_BG_BASE + $urandom_range(0, 7);
      7:       return SGR_BG_DEF;
      8, 9:    return SGR_FG_LIGHT + $urandom_range(0, 7);
      10, 11:  return SGR_BG_LIGHT + $urandom_range(0, 7);
      12:      return $urandom_range(0, 130);
      default: begin
        // large values, some past 65535 so saturation matters
        if ($urandom_range(0, 1)) return $urandom_range(65500, 65535);
        return $urandom_range(65536, 9999999);
      end
    endcase
  endfunction

  function automatic logic [7:0] other_final();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_SEMI || b == CH_M);
    return b;
  endfunction

  task automatic send_glyphs(input int n);
    repeat (n) put(8'($urandom_range(CH_SPACE, 8'h7f)), ($urandom_range(0, 9) == 0));
  endtask

  task automatic send_sgr_sequence();
    int         args [$];
    int         n;
    int         chans;
    logic [7:0] fin;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 4);
    while (args.size() < n) begin
      if ($urandom_range(0, 4) == 0) begin
        args.push_back($urandom_range(0, 1) ? SGR_FG_EXT : SGR_BG_EXT);
        if ($urandom_range(0, 1)) begin
          args.push_back(EXT_INDEXED);
          if ($urandom_range(0, 7) != 0) args.push_back($urandom_range(0, 300));
        end else begin
          args.push_back(EXT_RGB);
          chans = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : 3;
          repeat (chans) args.push_back($urandom_range(0, 300));
        end
      end else begin
        args.push_back(pick_code());
      end
    end
    put(CH_ESC, 1'b0);
    put(CH_LBRK, stray_last());
    foreach (args[k]) begin
      if (k > 0) put(CH_SEMI, stray_last());
      send_number(args[k]);
    end
    fin = ($urandom_range(0, 7) == 0) ? other_final() : CH_M;
    put(fin, ($urandom_range(0, 4) == 0));
    send_glyphs($urandom_range(1, 3));
  endtask

  task automatic send_broken_sequence();
    logic [7:0] b;
    if ($urandom_range(0, 1)) begin
      // ESC followed by anything but '['
      put(CH_ESC, 1'b0);
      do b = 8'($urandom_range(0, 255)); while (b == CH_LBRK);
      put(b, stray_last());
    end else begin
      // run past the last parameter slot, then more digits and separators
      put(CH_ESC, 1'b0);
      put(CH_LBRK, 1'b0);
      repeat ($urandom_range(MAX_PARAMS, MAX_PARAMS + 4)) begin
        if ($urandom_range(0, 1)) put(8'($urandom_range(CH_ZERO, CH_NINE)), 1'b0);
        put(CH_SEMI, 1'b0);
      end
      put(($urandom_range(0, 2) == 0) ? other_final() : CH_M, stray_last());
    end
    send_glyphs($urandom_range(1, 2));
  endtask

  task automatic send_text_run();
    int         r;
    logic [7:0] b;
    repeat ($urandom_range(1, 8)) begin
      r = $urandom_range(0, 99);
      if (r < 85) b = 8'($urandom_range(CH_SPACE, 8'h7f));
      else if (r < 92) b = CH_LF;
      else b = CH_CR;
      put(b, ($urandom_range(0, 7) == 0));
    end
  endtask

  // Any byte value; mostly ignored by the block, so not counted
  task automatic send_noise();
    repeat ($urandom_range(1, 3))
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 1), 1'b0, 1'b0, '0);
  endtask

  // Result receiver: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int stall_left;
    int burst_left;
    stall_left = 0;
    burst_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left == 0 && sink_hold_ask) begin
        sink_hold_ask = 1'b0;
        stall_left = SINK_HOLD_CYCLES;
      end else if (stall_left == 0 && burst_left == 0) begin
        stall_left = pick_gap();
        burst_left = $urandom_range(1, 24);
      end
      if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        out_chan.ready <= 1'b1;
        burst_left--;
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (colored_chars.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: kind=%0d code=%02h fg=%06h bg=%06h",
                   out_chan.kind, out_chan.char_code, out_chan.fg_color, out_chan.bg_color);
        mismatches++;
      end else begin
        want = colored_chars.pop_front();
        if (out_chan.kind !== want.kind || out_chan.char_code !== want.code ||
            out_chan.fg_color !== want.fg || out_chan.bg_color !== want.bg) begin
          if (mismatches < 10)
            $display("result mismatch: want kind=%0d code=%02h fg=%06h bg=%06h, got kind=%0d code=%02h fg=%06h bg=%06h",
                     want.kind, want.code, want.fg, want.bg, out_chan.kind,
                     out_chan.char_code, out_chan.fg_color, out_chan.bg_color);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    int  r;
    int  next_mode;
    int  next_hold;
    bit  drained;
    rst_n                 <= 1'b0;
    in_chan.valid         <= 1'b0;
    in_chan.byte_in       <= '0;
    in_chan.last_in_write <= 1'b0;
    next_mode = 80;
    next_hold = 250;
    drained = 1'b0;

    pen_fg = FG_DEFAULT;
    pen_bg = BG_DEFAULT;
    scan_phase = PH_TEXT;
    clear_args();

    // plain bytes after reset
    dir_tab.push_back(shown(8'h41, 1'b0, KIND_GLYPH, 7'h41, FG_DEFAULT, BG_DEFAULT));
    dir_tab.push_back(shown(8'h7f, 1'b1, KIND_GLYPH, 7'h7f, FG_DEFAULT, BG_DEFAULT));
    dir_tab.push_back(shown(CH_SPACE, 1'b0, KIND_GLYPH, 7'h20, FG_DEFAULT, BG_DEFAULT));
    dir_tab.push_back(shown(CH_LF, 1'b0, KIND_LF, 7'h00, FG_DEFAULT, BG_DEFAULT));
    dir_tab.push_back(shown(CH_CR, 1'b0, KIND_CR, 7'h00, FG_DEFAULT, BG_DEFAULT));
    dir_tab.push_back(silent(8'h00, 1'b0));
    dir_tab.push_back(silent(8'hff, 1'b1));
    // lone ESC: dropped, next byte is text
    dir_tab.push_back(silent(CH_ESC, 1'b0));
    dir_tab.push_back(shown("Z", 1'b0, KIND_GLYPH, 7'h5a, FG_DEFAULT, BG_DEFAULT));
    // empty list resets, then swap
    dir_tab.push_back(calc(CH_ESC, 1'b0));
    dir_tab.push_back(calc(CH_LBRK, 1'b0));
    dir_tab.push_back(calc(CH_M, 1'b0));
    dir_tab.push_back(calc(CH_ESC, 1'b0));
    dir_tab.push_back(calc(CH_LBRK, 1'b0));
    dir_tab.push_back(calc("7", 1'b0));
    dir_tab.push_back(calc(CH_M, 1'b0));
    dir_tab.push_back(shown("a", 1'b0, KIND_GLYPH, 7'h61, BG_DEFAULT, FG_DEFAULT));
    // 65567 must saturate, not wrap to 31
    dir_tab.push_back(calc(CH_ESC, 1'b0));
    dir_tab.push_back(calc(CH_LBRK, 1'b0));
    dir_tab.push_back(calc("6", 1'b0));
    dir_tab.push_back(calc("5", 1'b0));
    dir_tab.push_back(calc("5", 1'b0));
    dir_tab.push_back(calc("6", 1'b0));
    dir_tab.push_back(calc("7", 1'b0));
    dir_tab.push_back(calc(CH_M, 1'b0));
    dir_tab.push_back(calc("b", 1'b0));
    // unknown final drops the list
    dir_tab.push_back(calc(CH_ESC, 1'b0));
    dir_tab.push_back(calc(CH_LBRK, 1'b0));
    dir_tab.push_back(calc("3", 1'b0));
    dir_tab.push_back(calc("1", 1'b0));
    dir_tab.push_back(calc("q", 1'b0));
    dir_tab.push_back(calc("c", 1'b0));
    // write ends mid-sequence: the 'm' after it is plain text
    dir_tab.push_back(calc(CH_ESC, 1'b0));
    dir_tab.push_back(calc(CH_LBRK, 1'b0));
    dir_tab.push_back(calc("4", 1'b1));
    dir_tab.push_back(calc(CH_M, 1'b0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i])
      send_byte(dir_tab[i].b, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].has,
                dir_tab[i].res);

    while (bytes_sent < RANDOM_BYTES) begin
      if (bytes_sent >= next_mode) begin
        steady = ($urandom_range(0, 4) == 0);
        next_mode = bytes_sent + 80;
      end
      if (bytes_sent >= next_hold) begin
        sink_hold_ask = 1'b1;
        next_hold = (next_hold < 900) ? 900 : RANDOM_BYTES + 1;
      end
      if (!drained && bytes_sent >= 600) begin
        // sender pause until every request has come back
        drained = 1'b1;
        in_chan.valid <= 1'b0;
        do @(posedge clk); while (colored_chars.size() != 0);
      end
      r = $urandom_range(0, 99);
      if (r < 50) send_sgr_sequence();
      else if (r < 75) send_text_run();
      else if (r < 88) send_broken_sequence();
      else send_noise();
    end

    in_chan.valid <= 1'b0;
    while (colored_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/asgr_pkg.sv
hdl/asgr_if.sv
hdl/asgr_parse.sv
hdl/asgr_sgr_walk.sv
hdl/ansi_sgr_color_stream_decoder.sv
tb/ansi_sgr_color_stream_decoder_tb.sv
